// ===== hw/rtl/button_hold_mode_controller_macros.svh =====
// Assertion macros shared by the button hold mode controller RTL.
`ifndef BUTTON_HOLD_MODE_CONTROLLER_MACROS_SVH
`define BUTTON_HOLD_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BHMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BHMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bhmc_pkg.sv =====
// Types, constants and helpers for the button hold mode controller.
package bhmc_pkg;

	localparam int NUM_MODES = 9;
	localparam int NUM_SLOTS = 5;
	localparam int HOLD_BITS = 16;
	localparam int THR_BITS = 16;
	localparam int CMP_BITS = (HOLD_BITS > THR_BITS) ? HOLD_BITS : THR_BITS;

	localparam int MODE_BITS = 4;
	localparam int SERIES_BITS = 2;
	localparam int SLOT_BITS = 3;
	localparam int SLOT_IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam int CFG_IDX_BITS = 8;
	localparam int IN_BITS = 8;
	localparam int RES_BITS = 1 + 2 + SERIES_BITS + MODE_BITS + 1 + SLOT_BITS;
	localparam int OUT_BITS = ((RES_BITS + 7) / 8) * 8;

	localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

	localparam logic [CFG_IDX_BITS-1:0] REG_STEP = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_SERIES = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_SAVE = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_TOGGLE = CFG_IDX_BITS'(3);

	localparam logic [SERIES_BITS-1:0] SERIES_A = SERIES_BITS'(1);
	localparam logic [SERIES_BITS-1:0] SERIES_B = SERIES_BITS'(2);

	typedef enum logic [1:0] {
		STATUS_NORMAL = 2'd0,
		STATUS_SAVE = 2'd1,
		STATUS_TOGGLE = 2'd2
	} status_t;

	typedef struct packed {
		logic [THR_BITS-1:0] step;
		logic [THR_BITS-1:0] series;
		logic [THR_BITS-1:0] save;
		logic [THR_BITS-1:0] toggle;
	} thr_t;

	typedef struct packed {
		logic [HOLD_BITS-1:0] hold;
		logic last_pressed;
		logic [MODE_BITS-1:0] mode;
		logic [SERIES_BITS-1:0] series;
		logic fav;
		logic [SLOT_BITS-1:0] ptr;
		status_t status;
	} ctrl_t;

	typedef struct packed {
		logic en;
		logic [SLOT_IDX_BITS-1:0] pos;
	} save_t;

	localparam thr_t THR_RESET = '{
		step: THR_BITS'(14),
		series: THR_BITS'(700),
		save: THR_BITS'(3000),
		toggle: THR_BITS'(10000)
	};

	localparam ctrl_t CTRL_RESET = '{
		hold: '0,
		last_pressed: 1'b0,
		mode: MODE_BITS'(1),
		series: SERIES_A,
		fav: 1'b0,
		ptr: SLOT_BITS'(1),
		status: STATUS_NORMAL
	};

	// Storage position of a slot number; a number out of range maps to the first slot.
	function automatic logic [SLOT_IDX_BITS-1:0] slot_pos(input logic [SLOT_BITS-1:0] ptr);
		logic [SLOT_IDX_BITS-1:0] pos;
		pos = '0;
		if (ptr >= SLOT_BITS'(1) && ptr <= SLOT_BITS'(NUM_SLOTS))
			pos = SLOT_IDX_BITS'(ptr - SLOT_BITS'(1));
		return pos;
	endfunction

	// Slot i starts with mode i+1, or mode 1 when that is past the last mode.
	function automatic logic [MODE_BITS-1:0] slot_reset_mode(input int idx);
		logic [MODE_BITS-1:0] m;
		m = MODE_BITS'(1);
		if (idx + 1 <= NUM_MODES)
			m = MODE_BITS'(idx + 1);
		return m;
	endfunction

endpackage

// ===== hw/rtl/bhmc_eval.sv =====
// Next-state evaluation for one button tick: hold counting, classification, actions.
module bhmc_eval (
	input logic pressed,
	input bhmc_pkg::ctrl_t cur,
	input bhmc_pkg::thr_t thr,
	output bhmc_pkg::ctrl_t nxt,
	output bhmc_pkg::save_t save,
	output logic done
);

	logic [bhmc_pkg::HOLD_BITS-1:0] hold_inc;
	logic [bhmc_pkg::CMP_BITS-1:0] hold_cmp;
	logic gt_step, gt_series, gt_save, gt_toggle;
	logic released;
	logic [bhmc_pkg::SLOT_BITS-1:0] ptr_adv;
	logic [bhmc_pkg::MODE_BITS-1:0] mode_adv;

	assign released = !pressed;
	assign hold_inc = (pressed && cur.hold != bhmc_pkg::HOLD_MAX) ?
		cur.hold + bhmc_pkg::HOLD_BITS'(1) : cur.hold;
	assign hold_cmp = bhmc_pkg::CMP_BITS'(hold_inc);

	assign gt_toggle = hold_cmp > bhmc_pkg::CMP_BITS'(thr.toggle);
	assign gt_save = hold_cmp > bhmc_pkg::CMP_BITS'(thr.save);
	assign gt_series = hold_cmp > bhmc_pkg::CMP_BITS'(thr.series);
	assign gt_step = hold_cmp > bhmc_pkg::CMP_BITS'(thr.step);

	assign ptr_adv = (cur.ptr >= bhmc_pkg::SLOT_BITS'(bhmc_pkg::NUM_SLOTS)) ?
		bhmc_pkg::SLOT_BITS'(1) : cur.ptr + bhmc_pkg::SLOT_BITS'(1);
	assign mode_adv = (cur.mode >= bhmc_pkg::MODE_BITS'(bhmc_pkg::NUM_MODES)) ?
		bhmc_pkg::MODE_BITS'(1) : cur.mode + bhmc_pkg::MODE_BITS'(1);

	always_comb begin
		nxt = cur;
		nxt.hold = hold_inc;
		save.en = 1'b0;
		save.pos = bhmc_pkg::slot_pos(cur.ptr);
		done = 1'b0;

		// Thresholds are taken from the highest down; the first exceeded decides.
		if (pressed == cur.last_pressed) begin
			if (gt_toggle) begin
				nxt.status = bhmc_pkg::STATUS_TOGGLE;
				if (released) begin
					nxt.fav = !cur.fav;
					nxt.status = bhmc_pkg::STATUS_NORMAL;
					done = 1'b1;
				end
			end else if (gt_save) begin
				if (!cur.fav) begin
					nxt.status = bhmc_pkg::STATUS_SAVE;
					if (released) begin
						save.en = 1'b1;
						nxt.ptr = ptr_adv;
						nxt.status = bhmc_pkg::STATUS_NORMAL;
						done = 1'b1;
					end
				end
			end else if (gt_series) begin
				if (!cur.fav && released) begin
					nxt.series = (cur.series == bhmc_pkg::SERIES_A) ?
						bhmc_pkg::SERIES_B : bhmc_pkg::SERIES_A;
					nxt.mode = bhmc_pkg::MODE_BITS'(1);
					done = 1'b1;
				end
			end else if (gt_step) begin
				if (released) begin
					if (!cur.fav)
						nxt.mode = mode_adv;
					else
						nxt.ptr = ptr_adv;
					done = 1'b1;
				end
			end
		end

		// second released tick in a row ends the hold
		if (!pressed && !cur.last_pressed)
			nxt.hold = '0;
		nxt.last_pressed = pressed;
	end

endmodule

// ===== hw/rtl/button_hold_mode_controller.sv =====
// Top level of the button hold mode controller: registers, favourite slots, result stage.
// One item per clock: each accepted item is a button tick, and its result is in the output
// register the next cycle, while the next tick may be accepted in that same cycle; the
// control state loop through the evaluation logic sets this rate. With the
// result still unread and m_tready low, s_tready drops until it is taken. The result packs,
// from bit 0: action_done, status, shown_series, shown_mode, favourites_on, slot_index. The
// four thresholds are written on the cfg channel (0 step, 1 series, 2 save, 3 toggle), which
// is always ready; other indices are ignored.
`include "button_hold_mode_controller_macros.svh"

module button_hold_mode_controller (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [bhmc_pkg::IN_BITS-1:0] s_tdata, // [0] button_pressed
	output logic m_tvalid,
	input logic m_tready,
	// [0] action_done, [2:1] status, [4:3] shown_series, [8:5] shown_mode,
	// [9] favourites_on, [12:10] slot_index
	output logic [bhmc_pkg::OUT_BITS-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bhmc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [bhmc_pkg::THR_BITS-1:0] cfg_data
);

	bhmc_pkg::thr_t thr_q;
	bhmc_pkg::ctrl_t ctrl_q, ctrl_nxt;
	bhmc_pkg::save_t save;
	logic done;
	logic s_accept;
	logic m_tvalid_q;
	logic [bhmc_pkg::OUT_BITS-1:0] m_tdata_q;

	logic [bhmc_pkg::MODE_BITS-1:0] slot_mode_q [bhmc_pkg::NUM_SLOTS];
	logic [bhmc_pkg::SERIES_BITS-1:0] slot_series_q [bhmc_pkg::NUM_SLOTS];

	logic [bhmc_pkg::SLOT_IDX_BITS-1:0] show_pos;
	logic [bhmc_pkg::MODE_BITS-1:0] show_mode;
	logic [bhmc_pkg::SERIES_BITS-1:0] show_series;
	logic [bhmc_pkg::RES_BITS-1:0] res;

	assign cfg_ready = 1'b1;
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	bhmc_eval u_eval (
		.pressed(s_tdata[0]),
		.cur(ctrl_q),
		.thr(thr_q),
		.nxt(ctrl_nxt),
		.save(save),
		.done(done)
	);

	// The pointer may move this tick; a saving tick never shows slot contents, so the
	// old slot store read at the new pointer is what the item sees.
	assign show_pos = bhmc_pkg::slot_pos(ctrl_nxt.ptr);
	assign show_mode = ctrl_nxt.fav ? slot_mode_q[show_pos] : ctrl_nxt.mode;
	assign show_series = ctrl_nxt.fav ? slot_series_q[show_pos] : ctrl_nxt.series;
	assign res = {ctrl_nxt.ptr, ctrl_nxt.fav, show_mode, show_series, ctrl_nxt.status, done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bhmc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bhmc_pkg::REG_STEP: thr_q.step <= cfg_data;
				bhmc_pkg::REG_SERIES: thr_q.series <= cfg_data;
				bhmc_pkg::REG_SAVE: thr_q.save <= cfg_data;
				bhmc_pkg::REG_TOGGLE: thr_q.toggle <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= bhmc_pkg::CTRL_RESET;
		end else if (s_accept) begin
			ctrl_q <= ctrl_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bhmc_pkg::NUM_SLOTS; i++) begin
				slot_mode_q[i] <= bhmc_pkg::slot_reset_mode(i);
				slot_series_q[i] <= bhmc_pkg::SERIES_A;
			end
		end else if (s_accept && save.en) begin
			slot_mode_q[save.pos] <= ctrl_q.mode;
			slot_series_q[save.pos] <= ctrl_q.series;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata_q <= bhmc_pkg::OUT_BITS'(res);
		end
	end

	`BHMC_ASSERT_NOW(a_ptr_range, 1'b1, ctrl_q.ptr >= bhmc_pkg::SLOT_BITS'(1) && ctrl_q.ptr <= bhmc_pkg::SLOT_BITS'(bhmc_pkg::NUM_SLOTS), "slot pointer out of range")
	`BHMC_ASSERT_NOW(a_mode_range, 1'b1, ctrl_q.mode >= bhmc_pkg::MODE_BITS'(1) && ctrl_q.mode <= bhmc_pkg::MODE_BITS'(bhmc_pkg::NUM_MODES), "mode out of range")
	`BHMC_ASSERT_NEXT(a_result_follows, s_accept, m_tvalid, "accepted item gave no result")
	`BHMC_ASSERT_NEXT(a_press_no_action, s_accept && s_tdata[0], !m_tdata[0], "action on a pressed tick")
	`BHMC_ASSERT_NEXT(a_hold_clears, s_accept && !s_tdata[0] && !ctrl_q.last_pressed, ctrl_q.hold == '0, "hold count kept after two released ticks")

endmodule

// ===== bench/button_hold_mode_controller_test.sv =====
// Self-checking bench for the button hold mode controller: tick stream in, pattern stream out.

typedef struct packed {
	logic done;
	bhmc_pkg::status_t status;
	logic [bhmc_pkg::SERIES_BITS-1:0] series;
	logic [bhmc_pkg::MODE_BITS-1:0] mode;
	logic fav;
	logic [bhmc_pkg::SLOT_BITS-1:0] slot;
} shown_t;

// Tracks controller state per accepted tick and checks each result item in order.
class hold_pattern_tracker;
	bhmc_pkg::thr_t thr;
	logic [bhmc_pkg::HOLD_BITS-1:0] hold;
	logic was_pressed;
	logic [bhmc_pkg::MODE_BITS-1:0] mode;
	logic [bhmc_pkg::SERIES_BITS-1:0] series;
	logic fav;
	logic [bhmc_pkg::SLOT_BITS-1:0] ptr;
	bhmc_pkg::status_t status;
	logic [bhmc_pkg::MODE_BITS-1:0] slot_mode[bhmc_pkg::NUM_SLOTS];
	logic [bhmc_pkg::SERIES_BITS-1:0] slot_ser[bhmc_pkg::NUM_SLOTS];
	shown_t expected_patterns[$];
	int errors;

	function new();
		thr = bhmc_pkg::THR_RESET;
		hold = '0;
		was_pressed = 1'b0;
		mode = bhmc_pkg::MODE_BITS'(1);
		series = bhmc_pkg::SERIES_A;
		fav = 1'b0;
		ptr = bhmc_pkg::SLOT_BITS'(1);
		status = bhmc_pkg::STATUS_NORMAL;
		for (int i = 0; i < bhmc_pkg::NUM_SLOTS; i++) begin
			slot_mode[i] = bhmc_pkg::MODE_BITS'((i + 1 <= bhmc_pkg::NUM_MODES) ? i + 1 : 1);
			slot_ser[i] = bhmc_pkg::SERIES_A;
		end
		errors = 0;
	endfunction

	function void set_threshold(logic [bhmc_pkg::CFG_IDX_BITS-1:0] idx,
			logic [bhmc_pkg::THR_BITS-1:0] val);
		case (idx)
			bhmc_pkg::REG_STEP: thr.step = val;
			bhmc_pkg::REG_SERIES: thr.series = val;
			bhmc_pkg::REG_SAVE: thr.save = val;
			bhmc_pkg::REG_TOGGLE: thr.toggle = val;
			default: ;
		endcase
	endfunction

	function int slot_at();
		if (ptr >= 1 && int'(ptr) <= bhmc_pkg::NUM_SLOTS)
			return int'(ptr) - 1;
		return 0;
	endfunction

	function void next_slot();
		if (int'(ptr) >= bhmc_pkg::NUM_SLOTS)
			ptr = bhmc_pkg::SLOT_BITS'(1);
		else
			ptr = ptr + bhmc_pkg::SLOT_BITS'(1);
	endfunction

	function shown_t predict_pattern(logic pressed);
		shown_t r;
		int p;
		r.done = 1'b0;
		if (pressed && hold != bhmc_pkg::HOLD_MAX)
			hold = hold + bhmc_pkg::HOLD_BITS'(1);
		// thresholds tried from the top down, first one exceeded wins
		if (pressed == was_pressed) begin
			if (hold > thr.toggle) begin
				status = bhmc_pkg::STATUS_TOGGLE;
				if (!pressed) begin
					fav = !fav;
					status = bhmc_pkg::STATUS_NORMAL;
					r.done = 1'b1;
				end
			end else if (hold > thr.save) begin
				if (!fav) begin
					status = bhmc_pkg::STATUS_SAVE;
					if (!pressed) begin
						p = slot_at();
						slot_mode[p] = mode;
						slot_ser[p] = series;
						next_slot();
						status = bhmc_pkg::STATUS_NORMAL;
						r.done = 1'b1;
					end
				end
			end else if (hold > thr.series) begin
				if (!fav && !pressed) begin
					series = (series == bhmc_pkg::SERIES_A) ? bhmc_pkg::SERIES_B
						: bhmc_pkg::SERIES_A;
					mode = bhmc_pkg::MODE_BITS'(1);
					r.done = 1'b1;
				end
			end else if (hold > thr.step) begin
				if (!pressed) begin
					if (fav)
						next_slot();
					else if (int'(mode) >= bhmc_pkg::NUM_MODES)
						mode = bhmc_pkg::MODE_BITS'(1);
					else
						mode = mode + bhmc_pkg::MODE_BITS'(1);
					r.done = 1'b1;
				end
			end
		end
		if (!pressed && !was_pressed)
			hold = '0;
		was_pressed = pressed;
		r.status = status;
		r.fav = fav;
		r.slot = ptr;
		if (fav) begin
			r.series = slot_ser[slot_at()];
			r.mode = slot_mode[slot_at()];
		end else begin
			r.series = series;
			r.mode = mode;
		end
		return r;
	endfunction

	function void note_tick(logic pressed);
		expected_patterns.push_back(predict_pattern(pressed));
	endfunction

	function int pending();
		return expected_patterns.size();
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_field(string name, logic [3:0] got, logic [3:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task check_pattern(logic [bhmc_pkg::OUT_BITS-1:0] d);
		shown_t want;
		if (expected_patterns.size() == 0) begin
			report($sformatf("unexpected result item %h", d));
			return;
		end
		want = expected_patterns.pop_front();
		check_field("action_done", 4'(d[0]), 4'(want.done));
		check_field("status", 4'(d[2:1]), 4'(want.status));
		check_field("shown_series", 4'(d[4:3]), 4'(want.series));
		check_field("shown_mode", 4'(d[8:5]), 4'(want.mode));
		check_field("favourites_on", 4'(d[9]), 4'(want.fav));
		check_field("slot_index", 4'(d[12:10]), 4'(want.slot));
	endtask
endclass

module button_hold_mode_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_OFF_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [bhmc_pkg::IN_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [bhmc_pkg::OUT_BITS-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bhmc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [bhmc_pkg::THR_BITS-1:0] cfg_data = '0;

	hold_pattern_tracker tracker = new();
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_off_requests = 0;
	int hold_off_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	button_hold_mode_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random back-pressure, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_off_requests != hold_off_seen) begin
			hold_off_seen = hold_off_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_pattern(m_tdata);
	end

	// called and returns at a falling edge
	task automatic drive_tick(input logic pressed);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= bhmc_pkg::IN_BITS'(pressed);
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_tick(pressed);
		@(negedge clk);
	endtask

	task automatic hold_button(input int presses, input int releases);
		repeat (presses) drive_tick(1'b1);
		repeat (releases) drive_tick(1'b0);
	endtask

	task automatic write_reg(input logic [bhmc_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [bhmc_pkg::THR_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_threshold(idx, val);
		@(negedge clk);
	endtask

	// drains the block first, so registers only change while it is idle
	task automatic load_thresholds(input int step_t, input int series_t, input int save_t,
			input int toggle_t);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(bhmc_pkg::REG_STEP, bhmc_pkg::THR_BITS'(step_t));
		write_reg(bhmc_pkg::REG_SERIES, bhmc_pkg::THR_BITS'(series_t));
		write_reg(bhmc_pkg::REG_SAVE, bhmc_pkg::THR_BITS'(save_t));
		write_reg(bhmc_pkg::REG_TOGGLE, bhmc_pkg::THR_BITS'(toggle_t));
		// index past the register file must be ignored
		write_reg(bhmc_pkg::CFG_IDX_BITS'($urandom_range(255, int'(bhmc_pkg::REG_TOGGLE) + 1)),
			bhmc_pkg::THR_BITS'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// mostly clean press/release runs; a single released tick lets the hold keep counting
	task automatic run_random(input int count, input int longest);
		int sent;
		int presses;
		int releases;
		sent = 0;
		while (sent < count) begin
			presses = $urandom_range(longest, 1);
			releases = ($urandom_range(99) < 80) ? $urandom_range(4, 2) : 1;
			hold_button(presses, releases);
			sent += presses + releases;
		end
	endtask

	// holds just at and just past each threshold
	int long_holds[8] = '{6, 7, 10, 11, 14, 15, 18, 19};

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct = 16;
		sink_idle_pct = 83;
		load_thresholds(1, 2, 3, 4);
		hold_button(1, 2);
		hold_button(2, 2);
		hold_button(3, 2);
		hold_button(4, 2);
		hold_button(5, 2);
		run_random(200, 7);
		load_thresholds(2, 5, 9, 14);
		run_random(150, 17);

		src_idle_pct = 83;
		sink_idle_pct = 16;
		load_thresholds(65535, 3, 1, 6);
		run_random(150, 9);
		load_thresholds(1, 1, 1, 1);
		run_random(80, 4);
		load_thresholds(3, 9, 6, 65535);
		run_random(120, 12);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		load_thresholds(1, 3, 6, 10);
		hold_off_requests++;
		run_random(150, 13);
		load_thresholds(6, 10, 14, 18);
		foreach (long_holds[i])
			hold_button(long_holds[i], 2);

		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bhmc_pkg.sv
hw/rtl/bhmc_eval.sv
hw/rtl/button_hold_mode_controller.sv
bench/button_hold_mode_controller_test.sv
